// ----- rtl/core/rgbcc_pkg.sv -----
// Package for the RGB colour classifier: transaction payload types, the
// configuration register set, register indexes and class codes.
// No dependencies; used by rgbcc_classify and rgb_color_classifier_core.
package rgbcc_pkg;

	localparam int COUNT_W = 16;
	localparam int SHARE_W = 10;
	localparam int CLASS_W = 3;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [SHARE_W-1:0] SHARE_SCALE = 10'd1000;
	localparam logic [SHARE_W-1:0] CHANNEL_FLOOR = 10'd15;

	localparam logic [CLASS_W-1:0] CLASS_RED = 3'd0;
	localparam logic [CLASS_W-1:0] CLASS_BLUE = 3'd1;
	localparam logic [CLASS_W-1:0] CLASS_GREEN = 3'd2;
	localparam logic [CLASS_W-1:0] CLASS_WHITE = 3'd3;
	localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_WHITE_CLEAR_THRESHOLD = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RED_OVER_GREEN_MARGIN = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RED_OVER_BLUE_MARGIN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_MARGIN = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_RED_CEILING = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_GREEN_FLOOR = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_BLUE_FLOOR = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_GB_TOLERANCE = 4'd7;

	typedef struct packed {
		logic [COUNT_W-1:0] red_count;
		logic [COUNT_W-1:0] green_count;
		logic [COUNT_W-1:0] blue_count;
		logic [COUNT_W-1:0] clear_count;
	} reading_t;

	typedef struct packed {
		logic [CLASS_W-1:0] color_class;
		logic               matched;
		logic [SHARE_W-1:0] red_share;
		logic [SHARE_W-1:0] green_share;
		logic [SHARE_W-1:0] blue_share;
		logic [SHARE_W-1:0] share_spread;
	} result_t;

	typedef struct packed {
		logic [COUNT_W-1:0] white_clear_threshold;
		logic [SHARE_W-1:0] red_over_green_margin;
		logic [SHARE_W-1:0] red_over_blue_margin;
		logic [SHARE_W-1:0] blue_margin;
		logic [SHARE_W-1:0] green_red_ceiling;
		logic [SHARE_W-1:0] green_green_floor;
		logic [SHARE_W-1:0] green_blue_floor;
		logic [SHARE_W-1:0] green_gb_tolerance;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		white_clear_threshold: 16'd15000,
		red_over_green_margin: 10'd71,
		red_over_blue_margin:  10'd27,
		blue_margin:           10'd180,
		green_red_ceiling:     10'd220,
		green_green_floor:     10'd380,
		green_blue_floor:      10'd380,
		green_gb_tolerance:    10'd55
	};

endpackage

// ----- rtl/core/rgbcc_classify.sv -----
// Share spread and priority class decision for one set of shares.
// Depends on rgbcc_pkg (cfg_t, result_t, class codes, channel floor).
module rgbcc_classify (
	input  logic [rgbcc_pkg::SHARE_W-1:0] red_share,
	input  logic [rgbcc_pkg::SHARE_W-1:0] green_share,
	input  logic [rgbcc_pkg::SHARE_W-1:0] blue_share,
	input  logic                          is_white,
	input  rgbcc_pkg::cfg_t               cfg,
	output rgbcc_pkg::result_t            result
);

	logic [rgbcc_pkg::SHARE_W-1:0] d_rg, d_rb, d_br, d_bg, gb_abs, mx, mn;
	logic r_gt_g, r_gt_b, b_gt_r, b_gt_g, g_ge_b;
	logic red_ok, green_ok, blue_ok;

	assign r_gt_g = red_share > green_share;
	assign r_gt_b = red_share > blue_share;
	assign b_gt_r = blue_share > red_share;
	assign b_gt_g = blue_share > green_share;
	assign g_ge_b = green_share >= blue_share;

	// differences are only looked at where the sign is known to be positive
	assign d_rg = red_share - green_share;
	assign d_rb = red_share - blue_share;
	assign d_br = blue_share - red_share;
	assign d_bg = blue_share - green_share;
	assign gb_abs = g_ge_b ? (green_share - blue_share) : d_bg;

	assign red_ok = r_gt_g && r_gt_b
		&& (d_rg >= cfg.red_over_green_margin)
		&& (d_rb >= cfg.red_over_blue_margin)
		&& (green_share >= rgbcc_pkg::CHANNEL_FLOOR)
		&& (blue_share >= rgbcc_pkg::CHANNEL_FLOOR);

	assign green_ok = (red_share <= cfg.green_red_ceiling)
		&& (green_share >= cfg.green_green_floor)
		&& (blue_share >= cfg.green_blue_floor)
		&& (gb_abs <= cfg.green_gb_tolerance);

	assign blue_ok = b_gt_r && b_gt_g
		&& (d_br >= cfg.blue_margin)
		&& (d_bg >= cfg.blue_margin)
		&& (red_share >= rgbcc_pkg::CHANNEL_FLOOR)
		&& (green_share >= rgbcc_pkg::CHANNEL_FLOOR);

	always_comb begin
		mx = red_share;
		mn = red_share;
		if (green_share > mx) mx = green_share;
		if (blue_share > mx) mx = blue_share;
		if (green_share < mn) mn = green_share;
		if (blue_share < mn) mn = blue_share;
	end

	always_comb begin
		if (is_white) begin
			result.color_class = rgbcc_pkg::CLASS_WHITE;
		end else if (red_ok) begin
			result.color_class = rgbcc_pkg::CLASS_RED;
		end else if (green_ok) begin
			result.color_class = rgbcc_pkg::CLASS_GREEN;
		end else if (blue_ok) begin
			result.color_class = rgbcc_pkg::CLASS_BLUE;
		end else begin
			result.color_class = rgbcc_pkg::CLASS_UNKNOWN;
		end
		result.matched      = is_white || red_ok || green_ok || blue_ok;
		result.red_share    = red_share;
		result.green_share  = green_share;
		result.blue_share   = blue_share;
		result.share_spread = mx - mn;
	end

endmodule

// ----- rtl/core/rgb_color_classifier_core.sv -----
// Top level of the RGB colour classifier: input stage, ten-stage share
// divider and class output stage. Depends on rgbcc_pkg and rgbcc_classify.
//
// Usage
//   reading channel: reading_valid / reading_ready carry one sensor reading
//     (red, green, blue, clear counts) per transaction.
//   result channel: result_valid / result_ready carry one result per reading,
//     in order: class, matched flag, three shares in thousandths, spread.
//   cfg port: cfg_we with cfg_index and cfg_wdata writes one register at the
//     clock edge; indexes above the register list are dropped. Write only
//     while no reading is in flight.
// Pipeline: one input stage, ten divider stages and one class stage lie
//   between an accepted reading and result_valid.
// Throughput: one reading per cycle while result_ready is high. The rate is
//   set by the restoring divider, which resolves one quotient bit per stage
//   for all three channels at once, so each stage holds a different reading.
// Reset: arst_n clears every stage valid bit and loads the register
//   defaults; payload registers are left as they are.
// Stall: each stage advances when it is empty or the next one advances, so
//   a held result stalls only the stages that are full behind it; bubbles
//   are squeezed out and nothing is lost or repeated.
module rgb_color_classifier_core #(
	parameter int CHANNEL_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            reading_valid,
	output logic                            reading_ready,
	input  rgbcc_pkg::reading_t             reading,
	output logic                            result_valid,
	input  logic                            result_ready,
	output rgbcc_pkg::result_t              result,
	input  logic                            cfg_we,
	input  logic [rgbcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rgbcc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int SW = rgbcc_pkg::SHARE_W;
	localparam int SUM_W = CHANNEL_BITS + 2;
	localparam int NUM_W = CHANNEL_BITS + SW;
	localparam int REM_W = SUM_W + SW;
	localparam int NSTG = SW;

	// ---------------- configuration registers ----------------
	rgbcc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= rgbcc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rgbcc_pkg::REG_WHITE_CLEAR_THRESHOLD: begin
					cfg_q.white_clear_threshold <= cfg_wdata;
				end
				rgbcc_pkg::REG_RED_OVER_GREEN_MARGIN: begin
					cfg_q.red_over_green_margin <= cfg_wdata[SW-1:0];
				end
				rgbcc_pkg::REG_RED_OVER_BLUE_MARGIN: begin
					cfg_q.red_over_blue_margin <= cfg_wdata[SW-1:0];
				end
				rgbcc_pkg::REG_BLUE_MARGIN: begin
					cfg_q.blue_margin <= cfg_wdata[SW-1:0];
				end
				rgbcc_pkg::REG_GREEN_RED_CEILING: begin
					cfg_q.green_red_ceiling <= cfg_wdata[SW-1:0];
				end
				rgbcc_pkg::REG_GREEN_GREEN_FLOOR: begin
					cfg_q.green_green_floor <= cfg_wdata[SW-1:0];
				end
				rgbcc_pkg::REG_GREEN_BLUE_FLOOR: begin
					cfg_q.green_blue_floor <= cfg_wdata[SW-1:0];
				end
				rgbcc_pkg::REG_GREEN_GB_TOLERANCE: begin
					cfg_q.green_gb_tolerance <= cfg_wdata[SW-1:0];
				end
				default: begin
					// out-of-range index: drop the write
				end
			endcase
		end
	end

	// ---------------- stage 1: mask, sum, scale ----------------
	logic [CHANNEL_BITS-1:0] r_in, g_in, b_in, c_in;
	logic [SUM_W-1:0]        sum_in;
	logic [NUM_W-1:0]        num_r_in, num_g_in, num_b_in;

	assign r_in = reading.red_count[CHANNEL_BITS-1:0];
	assign g_in = reading.green_count[CHANNEL_BITS-1:0];
	assign b_in = reading.blue_count[CHANNEL_BITS-1:0];
	assign c_in = reading.clear_count[CHANNEL_BITS-1:0];
	assign sum_in = SUM_W'(r_in) + SUM_W'(g_in) + SUM_W'(b_in);
	// constant multiplier: a few shifted adds each
	assign num_r_in = NUM_W'(r_in) * NUM_W'(rgbcc_pkg::SHARE_SCALE);
	assign num_g_in = NUM_W'(g_in) * NUM_W'(rgbcc_pkg::SHARE_SCALE);
	assign num_b_in = NUM_W'(b_in) * NUM_W'(rgbcc_pkg::SHARE_SCALE);

	logic             v_s1;
	logic             rdy_s1;
	logic [REM_W-1:0] rem_r_s1, rem_g_s1, rem_b_s1;
	logic [SUM_W-1:0] sum_s1;
	logic             zero_s1, white_s1;

	// ---------------- divider stages (s2 .. s11) ----------------
	logic             v_sd     [NSTG];
	logic             rdy_sd   [NSTG];
	logic [REM_W-1:0] rem_r_sd [NSTG];
	logic [REM_W-1:0] rem_g_sd [NSTG];
	logic [REM_W-1:0] rem_b_sd [NSTG];
	logic [SW-1:0]    q_r_sd   [NSTG];
	logic [SW-1:0]    q_g_sd   [NSTG];
	logic [SW-1:0]    q_b_sd   [NSTG];
	logic [SUM_W-1:0] sum_sd   [NSTG];
	logic             zero_sd  [NSTG];
	logic             white_sd [NSTG];

	// ---------------- stage 12: result register ----------------
	logic               v_s12;
	logic               rdy_s12;
	rgbcc_pkg::result_t res_s12;

	assign rdy_s12 = !v_s12 || result_ready;
	assign rdy_s1 = !v_s1 || rdy_sd[0];
	assign reading_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= reading_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && reading_valid) begin
			rem_r_s1 <= REM_W'(num_r_in);
			rem_g_s1 <= REM_W'(num_g_in);
			rem_b_s1 <= REM_W'(num_b_in);
			sum_s1   <= sum_in;
			zero_s1  <= (sum_in == '0);
			white_s1 <= (rgbcc_pkg::COUNT_W'(c_in) >= cfg_q.white_clear_threshold);
		end
	end

	for (genvar j = 0; j < NSTG; j++) begin : g_div
		localparam int K = NSTG - 1 - j;
		logic             v_prev, rdy_next;
		logic [REM_W-1:0] pr_r, pr_g, pr_b, trial;
		logic [SW-1:0]    pq_r, pq_g, pq_b;
		logic [SUM_W-1:0] p_sum;
		logic             p_zero, p_white;
		logic             ge_r, ge_g, ge_b;

		if (j == 0) begin : g_first
			assign v_prev  = v_s1;
			assign pr_r    = rem_r_s1;
			assign pr_g    = rem_g_s1;
			assign pr_b    = rem_b_s1;
			assign pq_r    = '0;
			assign pq_g    = '0;
			assign pq_b    = '0;
			assign p_sum   = sum_s1;
			assign p_zero  = zero_s1;
			assign p_white = white_s1;
		end else begin : g_next
			assign v_prev  = v_sd[j-1];
			assign pr_r    = rem_r_sd[j-1];
			assign pr_g    = rem_g_sd[j-1];
			assign pr_b    = rem_b_sd[j-1];
			assign pq_r    = q_r_sd[j-1];
			assign pq_g    = q_g_sd[j-1];
			assign pq_b    = q_b_sd[j-1];
			assign p_sum   = sum_sd[j-1];
			assign p_zero  = zero_sd[j-1];
			assign p_white = white_sd[j-1];
		end

		if (j == NSTG - 1) begin : g_last
			assign rdy_next = rdy_s12;
		end else begin : g_mid
			assign rdy_next = rdy_sd[j+1];
		end

		// restoring step: try the divisor shifted to this quotient bit
		assign trial = REM_W'(p_sum) << K;
		assign ge_r = pr_r >= trial;
		assign ge_g = pr_g >= trial;
		assign ge_b = pr_b >= trial;
		assign rdy_sd[j] = !v_sd[j] || rdy_next;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[j] <= 1'b0;
			end else if (rdy_sd[j]) begin
				v_sd[j] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_sd[j] && v_prev) begin
				rem_r_sd[j] <= ge_r ? (pr_r - trial) : pr_r;
				rem_g_sd[j] <= ge_g ? (pr_g - trial) : pr_g;
				rem_b_sd[j] <= ge_b ? (pr_b - trial) : pr_b;
				q_r_sd[j]   <= {pq_r[SW-2:0], ge_r};
				q_g_sd[j]   <= {pq_g[SW-2:0], ge_g};
				q_b_sd[j]   <= {pq_b[SW-2:0], ge_b};
				sum_sd[j]   <= p_sum;
				zero_sd[j]  <= p_zero;
				white_sd[j] <= p_white;
			end
		end
	end

	// zero divisor makes every trial pass: force the shares to zero
	logic [SW-1:0]      rs, gs, bs;
	rgbcc_pkg::result_t cls_res;

	assign rs = zero_sd[NSTG-1] ? '0 : q_r_sd[NSTG-1];
	assign gs = zero_sd[NSTG-1] ? '0 : q_g_sd[NSTG-1];
	assign bs = zero_sd[NSTG-1] ? '0 : q_b_sd[NSTG-1];

	rgbcc_classify u_classify (
		.red_share   (rs),
		.green_share (gs),
		.blue_share  (bs),
		.is_white    (white_sd[NSTG-1]),
		.cfg         (cfg_q),
		.result      (cls_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (rdy_s12) begin
			v_s12 <= v_sd[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s12 && v_sd[NSTG-1]) begin
			res_s12 <= cls_res;
		end
	end

	assign result_valid = v_s12;
	assign result = res_s12;

	// ---------------- assertions ----------------
	// a free output drains the whole ready chain back to the input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> reading_ready)
		else $error("reading_ready low while result_ready high");

	a_spread_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.share_spread <= rgbcc_pkg::SHARE_SCALE)
			&& (result.red_share <= rgbcc_pkg::SHARE_SCALE))
		else $error("share or spread above full scale");

	a_red_dominant: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.color_class == rgbcc_pkg::CLASS_RED) |->
			(result.red_share > result.green_share)
			&& (result.red_share > result.blue_share))
		else $error("red class without dominant red share");

	a_matched: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			(result.matched == (result.color_class != rgbcc_pkg::CLASS_UNKNOWN)))
		else $error("matched flag disagrees with class");

endmodule
